// ===== rtl/ngmd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngmd_pkg
// Shared types and constants of the NRPN gain matrix decoder.
// ----------------------------------------------------------------------------
package ngmd_pkg;

  // Mixer size limit; count registers saturate here
  localparam logic [4:0] MaxPorts = 5'd16;

  // Control-change message type (status high nibble)
  localparam logic [3:0] MsgTypeCc = 4'hB;

  // Controller numbers
  localparam logic [6:0] CtrParamLsb = 7'h62;
  localparam logic [6:0] CtrParamMsb = 7'h63;
  localparam logic [6:0] CtrDataLsb  = 7'h26;
  localparam logic [6:0] CtrDataMsb  = 7'h06;

  // Gain scaling: (data - DataMid) * GainMul / 2^GainShift, towards zero
  localparam logic signed [14:0] DataMid   = 15'sd8191;
  localparam logic signed [22:0] GainMul   = 23'sd225;
  localparam logic signed [22:0] GainBias  = 23'sd511;
  localparam int unsigned        GainShift = 9;

  // Configuration register indices
  typedef enum logic {
    CFG_OUTPUT_COUNT = 1'b0,
    CFG_INPUT_COUNT  = 1'b1
  } cfg_idx_e;

  // Registered MIDI message
  typedef struct packed {
    logic       is_cc;
    logic [3:0] chan;
    logic [6:0] ctr;
    logic [6:0] value;
  } msg_t;

  // Channel word after the update for the current message
  typedef struct packed {
    logic        gain_req;  // message was a data-MSB control change
    logic [13:0] param;
    logic [13:0] data;
  } chan_upd_t;

endpackage

// ===== rtl/ngmd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngmd_cfg_regs
// Destination and source count registers, saturated to the mixer size.
// ----------------------------------------------------------------------------
module ngmd_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  ngmd_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [4:0]          cfg_data_i,
  output logic [4:0]          output_count_o,
  output logic [4:0]          input_count_o
);
  import ngmd_pkg::*;

  logic [4:0] out_cnt_q, out_cnt_d;
  logic [4:0] in_cnt_q, in_cnt_d;
  logic [4:0] clamped;

  assign clamped = (cfg_data_i > MaxPorts) ? MaxPorts : cfg_data_i;

  always_comb begin
    out_cnt_d = out_cnt_q;
    in_cnt_d  = in_cnt_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OUTPUT_COUNT: out_cnt_d = clamped;
        CFG_INPUT_COUNT:  in_cnt_d  = clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= 5'd1;
      in_cnt_q  <= 5'd1;
    end else begin
      out_cnt_q <= out_cnt_d;
      in_cnt_q  <= in_cnt_d;
    end
  end

  assign output_count_o = out_cnt_q;
  assign input_count_o  = in_cnt_q;

endmodule

// ===== rtl/ngmd_chan_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngmd_chan_state
// Per-channel parameter number and data word, updated by controller messages.
// ----------------------------------------------------------------------------
module ngmd_chan_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                upd_en_i,
  input  ngmd_pkg::msg_t      msg_i,
  output ngmd_pkg::chan_upd_t upd_o
);
  import ngmd_pkg::*;

  logic [13:0] param_q [16];
  logic [13:0] data_q  [16];
  logic [13:0] param_d;
  logic [13:0] data_d;
  logic        hit;
  logic        msb_hit;

  always_comb begin
    param_d = param_q[msg_i.chan];
    data_d  = data_q[msg_i.chan];
    hit     = 1'b1;
    msb_hit = 1'b0;
    unique case (msg_i.ctr)
      CtrParamLsb: param_d = {param_d[13:7], msg_i.value};
      CtrParamMsb: param_d = {msg_i.value, param_d[6:0]};
      CtrDataLsb:  data_d  = {data_d[13:7], msg_i.value};
      CtrDataMsb: begin
        data_d  = {msg_i.value, data_d[6:0]};
        msb_hit = 1'b1;
      end
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        param_q[i] <= '0;
        data_q[i]  <= '0;
      end
    end else if (upd_en_i && msg_i.is_cc && hit) begin
      param_q[msg_i.chan] <= param_d;
      data_q[msg_i.chan]  <= data_d;
    end
  end

  assign upd_o.gain_req = msg_i.is_cc && msb_hit;
  assign upd_o.param    = param_d;
  assign upd_o.data     = data_d;

endmodule

// ===== rtl/nrpn_gain_matrix_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrpn_gain_matrix_decoder
// MIDI NRPN control-change decoder producing crosspoint gain writes.
// ----------------------------------------------------------------------------
// Takes one three-byte MIDI message per transfer and accepts a new message
// every clock cycle while in_stall_o is low; a gain write passes through the
// input register and then the result register. Only control-change
// messages act. Per channel, controllers 0x62/0x63 set the low/high seven bits
// of the parameter number and 0x26/0x06 the low/high seven bits of the data
// word. A data-MSB message produces one gain write, destination = parameter
// high part, source = parameter low part, if both lie below the destination
// and source counts (counts are written through the config port and saturate
// at 16; reset value 1). The gain is (data - 8191) * 225 / 512 in hundredths
// of a dB, truncated towards zero, range -3599..3600. The channel state read,
// update and gain multiply all sit between the input and result registers,
// so back-to-back messages on the same channel see each other's updates.
// The input side stalls only while a finished gain write waits on out_stall_i.
// Counts should be written only while the block is idle.
// ----------------------------------------------------------------------------
module nrpn_gain_matrix_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  ngmd_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [4:0]          cfg_data_i,
  // message input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          status_byte_i,
  input  logic [6:0]          controller_number_i,
  input  logic [6:0]          controller_value_i,
  // gain write output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [3:0]          destination_index_o,
  output logic [3:0]          source_index_o,
  output logic signed [12:0]  gain_hundredth_db_o
);
  import ngmd_pkg::*;

  // config
  logic [4:0] out_count;
  logic [4:0] in_count;

  // input register
  logic in_valid_q, in_valid_d;
  msg_t msg_q;
  logic in_load;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [3:0]         dst_q;
  logic [3:0]         src_q;
  logic signed [12:0] gain_q;

  logic      out_free;
  logic      fire;
  logic      emit;
  chan_upd_t upd;
  logic [6:0] hi;
  logic [6:0] lo;

  // gain datapath
  logic signed [14:0] diff;
  logic signed [22:0] diff_ext;
  logic signed [22:0] prod;
  logic signed [22:0] prod_adj;
  logic signed [22:0] quot;

  ngmd_cfg_regs u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .output_count_o (out_count),
    .input_count_o  (in_count)
  );

  // Handshake: the held message moves on whenever the result register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = !in_stall_o;
  assign fire       = in_valid_q && out_free;
  assign in_valid_d = in_load ? in_valid_i : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      msg_q.is_cc <= (status_byte_i[7:4] == MsgTypeCc);
      msg_q.chan  <= status_byte_i[3:0];
      msg_q.ctr   <= controller_number_i;
      msg_q.value <= controller_value_i;
    end
  end

  // Channel state: read, modify and write back as the message leaves
  ngmd_chan_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_en_i (fire),
    .msg_i    (msg_q),
    .upd_o    (upd)
  );

  // Crosspoint range check; indices of 16 and above never pass
  assign hi   = upd.param[13:7];
  assign lo   = upd.param[6:0];
  assign emit = fire && upd.gain_req
             && ({2'b00, hi[6:4] == 3'd0 ? hi[4:0] : 5'd31} < {2'b00, out_count})
             && (hi[6:4] == 3'd0)
             && (lo[6:4] == 3'd0)
             && (lo[4:0] < in_count);

  // Gain: (data - 8191) * 225, then divide by 512 truncating towards zero
  assign diff     = $signed({1'b0, upd.data}) - DataMid;
  assign diff_ext = 23'(diff);
  assign prod     = diff_ext * GainMul;
  assign prod_adj = prod + (prod[22] ? GainBias : 23'sd0);
  assign quot     = prod_adj >>> GainShift;

  assign out_valid_d = out_free ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dst_q  <= hi[3:0];
      src_q  <= lo[3:0];
      gain_q <= quot[12:0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign destination_index_o = dst_q;
  assign source_index_o      = src_q;
  assign gain_hundredth_db_o = gain_q;

endmodule

// ===== bench/nrpn_gain_matrix_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrpn_gain_matrix_decoder_tb
// Self-checking bench for the NRPN gain matrix decoder.
// ----------------------------------------------------------------------------
// A queue of MIDI messages feeds a clocked driver. Each accepted transfer is
// run through a local decoder model that keeps per-channel NRPN state and
// predicts gain writes. A clocked monitor checks every gain write, field by
// field, against the oldest prediction. The run moves through several count
// settings and idle/stall mixes, including one long output hold-off.
// ----------------------------------------------------------------------------
module nrpn_gain_matrix_decoder_tb;
  import ngmd_pkg::*;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] ctr;
    logic [6:0] value;
  } midi_msg_t;

  typedef struct packed {
    logic [3:0]         dst;
    logic [3:0]         src;
    logic signed [12:0] gain;
  } gain_write_t;

  localparam int TailCycles = 8;     // settle time after the last write
  localparam int HoldCycles = 400;   // long output hold-off

  // clock, reset and block inputs, all known from time zero
  logic               clk_i               = 1'b0;
  logic               rst_ni              = 1'b0;
  logic               cfg_we_i            = 1'b0;
  cfg_idx_e           cfg_idx_i           = CFG_OUTPUT_COUNT;
  logic [4:0]         cfg_data_i          = '0;
  logic               in_valid_i          = 1'b0;
  logic [7:0]         status_byte_i       = '0;
  logic [6:0]         controller_number_i = '0;
  logic [6:0]         controller_value_i  = '0;
  logic               out_stall_i         = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [3:0]         destination_index_o;
  logic [3:0]         source_index_o;
  logic signed [12:0] gain_hundredth_db_o;

  // stimulus and checking state
  midi_msg_t   midi_q[$];        // messages waiting for the driver
  gain_write_t gain_write_q[$];  // predicted gain writes, oldest first
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_left     = 0;
  int          acted_items   = 0;
  int          mismatches    = 0;

  // local copy of the decoder state
  logic [4:0]  dst_count;
  logic [4:0]  src_count;
  logic [13:0] nrpn_param [16];
  logic [13:0] nrpn_data  [16];

  logic [6:0]  nrpn_ctrs [4] = '{CtrParamLsb, CtrParamMsb, CtrDataLsb, CtrDataMsb};

  nrpn_gain_matrix_decoder dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .status_byte_i       (status_byte_i),
    .controller_number_i (controller_number_i),
    .controller_value_i  (controller_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .destination_index_o (destination_index_o),
    .source_index_o      (source_index_o),
    .gain_hundredth_db_o (gain_hundredth_db_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // Decoder model
  // ------------------------------------------------------------------------

  // hundredths of a dB; SV division already truncates towards zero
  function automatic logic signed [12:0] gain_of_word(logic [13:0] word);
    int offset;
    offset = int'(word) - 8191;
    return 13'((offset * 225) / 512);
  endfunction

  function automatic logic [4:0] saturate_count(logic [4:0] v);
    return (v > MaxPorts) ? MaxPorts : v;
  endfunction

  // Applies one accepted message to the channel state, queueing a gain write
  // when a data-MSB lands on an in-range crosspoint.
  function automatic void decode_midi(midi_msg_t m);
    logic [3:0]  ch;
    logic [6:0]  hi;
    logic [6:0]  lo;
    gain_write_t w;
    if (m.status[7:4] != MsgTypeCc) return;
    ch = m.status[3:0];
    case (m.ctr)
      CtrParamLsb: nrpn_param[ch][6:0]  = m.value;
      CtrParamMsb: nrpn_param[ch][13:7] = m.value;
      CtrDataLsb:  nrpn_data[ch][6:0]   = m.value;
      CtrDataMsb: begin
        nrpn_data[ch][13:7] = m.value;
        hi = nrpn_param[ch][13:7];
        lo = nrpn_param[ch][6:0];
        // the data word is kept even when the crosspoint is out of range
        if (hi < dst_count && lo < src_count && hi < 7'd16 && lo < 7'd16) begin
          w.dst  = hi[3:0];
          w.src  = lo[3:0];
          w.gain = gain_of_word(nrpn_data[ch]);
          gain_write_q.push_back(w);
        end
      end
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Driver: offers queued messages, predicts on each completed transfer
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : midi_driver
    midi_msg_t m;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        m.status = status_byte_i;
        m.ctr    = controller_number_i;
        m.value  = controller_value_i;
        decode_midi(m);
      end
      // payload only moves once the current one has gone
      if (!in_valid_i || !in_stall_o) begin
        if (midi_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          m = midi_q.pop_front();
          in_valid_i          <= 1'b1;
          status_byte_i       <= m.status;
          controller_number_i <= m.ctr;
          controller_value_i  <= m.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Receiver: random stall, or a counted hold-off when one is requested
  // ------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ------------------------------------------------------------------------
  // Monitor: checks each gain write against the oldest prediction
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin : gain_monitor
    gain_write_t w;
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (gain_write_q.size() == 0) begin
        $display("%0t: unexpected gain write dst %0d src %0d gain %0d", $time,
                 destination_index_o, source_index_o, gain_hundredth_db_o);
        mismatches++;
      end else begin
        w = gain_write_q.pop_front();
        if (destination_index_o !== w.dst) begin
          $display("%0t: destination_index expected %0d, got %0d", $time,
                   w.dst, destination_index_o);
          mismatches++;
        end
        if (source_index_o !== w.src) begin
          $display("%0t: source_index expected %0d, got %0d", $time,
                   w.src, source_index_o);
          mismatches++;
        end
        if (gain_hundredth_db_o !== w.gain) begin
          $display("%0t: gain_hundredth_db expected %0d, got %0d", $time,
                   w.gain, gain_hundredth_db_o);
          mismatches++;
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers (queue pushes happen on the falling edge)
  // ------------------------------------------------------------------------
  task automatic push_midi(input logic [7:0] st, input logic [6:0] ctr,
                           input logic [6:0] val);
    midi_msg_t m;
    m.status = st;
    m.ctr    = ctr;
    m.value  = val;
    midi_q.push_back(m);
    // only the four NRPN controllers on a control change count as traffic
    if (st[7:4] == MsgTypeCc && (ctr == CtrParamLsb || ctr == CtrParamMsb ||
                                 ctr == CtrDataLsb || ctr == CtrDataMsb))
      acted_items++;
  endtask

  // all messages gone, nothing predicted outstanding, pipeline drained
  task automatic wait_idle();
    while (midi_q.size() != 0 || in_valid_i || gain_write_q.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
  endtask

  // writes both counts on back-to-back edges, enable held across them
  task automatic set_counts(input logic [4:0] dst, input logic [4:0] src);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_OUTPUT_COUNT;
    cfg_data_i <= dst;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_INPUT_COUNT;
    cfg_data_i <= src;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dst_count = saturate_count(dst);
    src_count = saturate_count(src);
    @(negedge clk_i);
  endtask

  // Mostly complete NRPN sequences with random content; the rest is data
  // re-sends, broken sequences and plain noise.
  task automatic queue_nrpn_traffic(input int target);
    int         start;
    int         kind;
    logic [7:0] st;
    logic [6:0] hi;
    logic [6:0] lo;
    start = acted_items;
    while (acted_items - start < target) begin
      kind = $urandom_range(0, 99);
      st   = {MsgTypeCc, 4'($urandom_range(0, 15))};
      hi   = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 17));
      lo   = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                         : 7'($urandom_range(0, 17));
      if (kind < 60) begin
        if ($urandom_range(0, 1) != 0) begin
          push_midi(st, CtrParamMsb, hi);
          push_midi(st, CtrParamLsb, lo);
        end else begin
          push_midi(st, CtrParamLsb, lo);
          push_midi(st, CtrParamMsb, hi);
        end
        push_midi(st, CtrDataLsb, 7'($urandom_range(0, 127)));
        push_midi(st, CtrDataMsb, 7'($urandom_range(0, 127)));
      end else if (kind < 75) begin
        if ($urandom_range(0, 1) != 0)
          push_midi(st, CtrDataLsb, 7'($urandom_range(0, 127)));
        push_midi(st, CtrDataMsb, 7'($urandom_range(0, 127)));
      end else if (kind < 88) begin
        if ($urandom_range(0, 1) != 0) push_midi(st, CtrParamMsb, hi);
        if ($urandom_range(0, 1) != 0)
          push_midi(st, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 1) != 0) push_midi(st, CtrParamLsb, lo);
        if ($urandom_range(0, 1) != 0)
          push_midi(st, CtrDataLsb, 7'($urandom_range(0, 127)));
        if ($urandom_range(0, 1) != 0)
          push_midi(st, CtrDataMsb, 7'($urandom_range(0, 127)));
      end else begin
        push_midi(8'($urandom_range(128, 255)),
                  ($urandom_range(0, 1) != 0) ? nrpn_ctrs[$urandom_range(0, 3)]
                                              : 7'($urandom_range(0, 127)),
                  7'($urandom_range(0, 127)));
      end
    end
  endtask

  task automatic run_phase(input logic [4:0] dst, input logic [4:0] src,
                           input int send_pct, input int stall_p, input int n);
    wait_idle();
    set_counts(dst, src);
    send_idle_pct = send_pct;
    stall_pct     = stall_p;
    queue_nrpn_traffic(n);
  endtask

  // ------------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------------
  initial begin : main_seq
    int idle_mix [3];
    idle_mix = '{0, 21, 64};
    dst_count = 5'd1;
    src_count = 5'd1;
    for (int i = 0; i < 16; i++) begin
      nrpn_param[i] = '0;
      nrpn_data[i]  = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed, counts still at their reset value of one
    push_midi({MsgTypeCc, 4'd3}, CtrDataMsb, 7'h7F);   // crosspoint 0/0 from reset
    push_midi(8'h80, CtrDataMsb, 7'h00);               // note off: ignored
    push_midi(8'hFF, 7'h7F, 7'h7F);                    // system message: ignored
    push_midi({MsgTypeCc, 4'd3}, 7'h07, 7'h40);        // volume controller: ignored
    push_midi({MsgTypeCc, 4'd3}, CtrParamMsb, 7'h01);
    push_midi({MsgTypeCc, 4'd3}, CtrDataMsb, 7'h40);   // destination out of range
    push_midi({MsgTypeCc, 4'd3}, CtrParamMsb, 7'h00);
    push_midi({MsgTypeCc, 4'd3}, CtrDataLsb, 7'h01);
    push_midi({MsgTypeCc, 4'd3}, CtrDataMsb, 7'h40);   // picks up the earlier update
    wait_idle();

    // directed, full mixer: gain extremes, rounding towards zero, top corner
    set_counts(5'd16, 5'd16);
    push_midi({MsgTypeCc, 4'd0}, CtrParamMsb, 7'h00);
    push_midi({MsgTypeCc, 4'd0}, CtrParamLsb, 7'h00);
    push_midi({MsgTypeCc, 4'd0}, CtrDataLsb, 7'h00);
    push_midi({MsgTypeCc, 4'd0}, CtrDataMsb, 7'h00);   // most negative gain
    push_midi({MsgTypeCc, 4'd0}, CtrDataLsb, 7'h7F);
    push_midi({MsgTypeCc, 4'd0}, CtrDataMsb, 7'h7F);   // most positive gain
    push_midi({MsgTypeCc, 4'd0}, CtrDataMsb, 7'h3F);   // mid-scale, zero gain
    push_midi({MsgTypeCc, 4'd0}, CtrDataLsb, 7'h7C);
    push_midi({MsgTypeCc, 4'd0}, CtrDataMsb, 7'h3F);   // small negative, truncated
    push_midi({MsgTypeCc, 4'd15}, CtrParamMsb, 7'h0F);
    push_midi({MsgTypeCc, 4'd15}, CtrParamLsb, 7'h0F);
    push_midi({MsgTypeCc, 4'd15}, CtrDataMsb, 7'h55);  // crosspoint 15/15
    push_midi({MsgTypeCc, 4'd15}, CtrParamMsb, 7'h10);
    push_midi({MsgTypeCc, 4'd15}, CtrDataMsb, 7'h2A);  // index 16: never a write
    push_midi(8'hA5, CtrDataMsb, 7'h2A);               // aftertouch: ignored

    // random traffic across count settings and idle/stall mixes
    run_phase(5'd16, 5'd16,  0,  0, 300);
    run_phase(5'd1,  5'd1,  64,  0, 150);
    run_phase(5'd31, 5'd3,   0, 64, 200);   // output count saturates
    run_phase(5'd4,  5'd17, 21, 21, 200);
    run_phase(5'd0,  5'd16,  0,  0,  60);   // no destinations at all
    run_phase(5'd16, 5'd0,  64, 64,  60);   // no sources at all
    for (int i = 0; i < 3; i++)
      run_phase(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                idle_mix[$urandom_range(0, 2)], idle_mix[$urandom_range(0, 2)], 120);

    // long output hold-off while the sender keeps offering, so the block
    // backs up and stalls its input side
    wait_idle();
    set_counts(5'd16, 5'd16);
    send_idle_pct = 0;
    stall_pct     = 21;
    hold_left     = HoldCycles;
    queue_nrpn_traffic(200);

    wait_idle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ngmd_pkg.sv
rtl/ngmd_cfg_regs.sv
rtl/ngmd_chan_state.sv
rtl/nrpn_gain_matrix_decoder.sv
bench/nrpn_gain_matrix_decoder_tb.sv
